// File: design/ngcs_pkg.sv
// Shared types and constants for the n-ary Gray code successor unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ngcs_pkg;

	localparam int NGCS_MAX_DIGITS = 8;
	localparam int NGCS_DIGIT_BITS = 4;

	localparam int WORD_W   = 32;
	localparam int RADIX_W  = 5;
	localparam int DIGITS_W = 4;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	// Register index as decoded from paddr[2]
	localparam logic REG_RADIX  = 1'b0;
	localparam logic REG_DIGITS = 1'b1;

	localparam logic [RADIX_W-1:0]  RADIX_RESET  = RADIX_W'(2);
	localparam logic [DIGITS_W-1:0] DIGITS_RESET = DIGITS_W'(8);

	typedef struct packed {
		logic [RADIX_W-1:0]  radix;
		logic [DIGITS_W-1:0] digits_in_use;
	} cfg_t;

endpackage

// File: design/ngcs_cfg_regs.sv
// APB register file holding the radix and the number of digits in use.
// Depends on ngcs_pkg for register indexes, widths and reset values.
`timescale 1ns / 1ps

module ngcs_cfg_regs import ngcs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [RADIX_W-1:0]  radix_q;
	logic [DIGITS_W-1:0] digits_q;
	logic                wr_en;
	logic                reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q  <= RADIX_RESET;
			digits_q <= DIGITS_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_RADIX:  radix_q  <= pwdata[RADIX_W-1:0];
				REG_DIGITS: digits_q <= pwdata[DIGITS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_RADIX:  prdata = PDATA_W'(radix_q);
			REG_DIGITS: prdata = PDATA_W'(digits_q);
			default:    prdata = '0;
		endcase
	end

	assign cfg.radix         = radix_q;
	assign cfg.digits_in_use = digits_q;

endmodule

// File: design/ngcs_digit_step.sv
// Successor logic: prefix parity, rightmost movable digit pick, clamp and pack.
// Depends on ngcs_pkg for cfg_t and word width.
`timescale 1ns / 1ps

module ngcs_digit_step import ngcs_pkg::*; #(
	parameter int MAX_DIGITS = NGCS_MAX_DIGITS,
	parameter int DIGIT_BITS = NGCS_DIGIT_BITS
) (
	input  cfg_t              cfg,
	input  logic [WORD_W-1:0] code_word,
	output logic [WORD_W-1:0] next_word,
	output logic              wrapped
);

	localparam int PACK_W = MAX_DIGITS * DIGIT_BITS;
	localparam int EXT_W  = PACK_W + WORD_W;
	localparam int BASE_W = (DIGIT_BITS + 1 > RADIX_W) ? DIGIT_BITS + 1 : RADIX_W;
	localparam logic [BASE_W-1:0] CAP   = BASE_W'(1 << DIGIT_BITS);
	localparam logic [BASE_W-1:0] TWO   = BASE_W'(2);

	logic [EXT_W-1:0]      word_ext;
	logic [EXT_W-1:0]      packed_ext;
	logic [BASE_W-1:0]     base;
	logic [BASE_W-1:0]     radix_ext;
	logic [DIGIT_BITS-1:0] top_digit;
	logic [DIGIT_BITS-1:0] dig     [MAX_DIGITS];
	logic [DIGIT_BITS-1:0] new_dig [MAX_DIGITS];
	logic [MAX_DIGITS-1:0] in_use;
	logic [MAX_DIGITS-1:0] up;
	logic [MAX_DIGITS-1:0] can;
	logic [MAX_DIGITS-1:0] free_below;
	logic                  par;
	logic                  seen;
	logic                  moved;

	assign word_ext  = {{PACK_W{1'b0}}, code_word};
	assign radix_ext = BASE_W'(cfg.radix);

	// Saturate the radix into 2..2^DIGIT_BITS
	always_comb begin
		if (radix_ext < TWO)
			base = TWO;
		else if (radix_ext > CAP)
			base = CAP;
		else
			base = radix_ext;
	end

	assign top_digit = DIGIT_BITS'(base - 1'b1);

	always_comb begin
		for (int k = 0; k < MAX_DIGITS; k++) begin
			dig[k]    = word_ext[k*DIGIT_BITS +: DIGIT_BITS];
			in_use[k] = (k == 0) || ((DIGITS_W+1)'(k) < {1'b0, cfg.digits_in_use});
		end
	end

	// Direction from the parity of the digits to the left, most significant first
	always_comb begin
		par = 1'b0;
		for (int k = MAX_DIGITS - 1; k >= 0; k--) begin
			up[k] = ~par;
			if (in_use[k])
				par = par ^ dig[k][0];
		end
	end

	always_comb begin
		for (int k = 0; k < MAX_DIGITS; k++) begin
			if (up[k])
				can[k] = in_use[k] && ((BASE_W'(dig[k]) + 1'b1) < base);
			else
				can[k] = in_use[k] && (dig[k] != '0) && ((BASE_W'(dig[k]) - 1'b1) < base);
		end
	end

	// free_below[k]: no digit under k can move
	always_comb begin
		seen = 1'b0;
		for (int k = 0; k < MAX_DIGITS; k++) begin
			free_below[k] = ~seen;
			seen = seen | can[k];
		end
	end

	assign moved = |can;

	always_comb begin
		for (int k = 0; k < MAX_DIGITS; k++) begin
			if (!in_use[k] || !moved)
				new_dig[k] = '0;
			else if (!free_below[k])
				new_dig[k] = dig[k];
			else if (can[k])
				new_dig[k] = up[k] ? dig[k] + 1'b1 : dig[k] - 1'b1;
			else
				new_dig[k] = up[k] ? top_digit : '0;
		end
	end

	always_comb begin
		packed_ext = '0;
		for (int k = 0; k < MAX_DIGITS; k++)
			packed_ext[k*DIGIT_BITS +: DIGIT_BITS] = new_dig[k];
	end

	assign next_word = packed_ext[WORD_W-1:0];
	assign wrapped   = ~moved;

endmodule

// File: design/nary_gray_code_successor_unit.sv
// Reflected n-ary Gray code successor unit.
// Slave stream: s_axis_tdata carries code_word, 4-bit digits, digit 0 in bits 3:0.
// Master stream: m_axis_tdata carries next_word, m_axis_tuser carries wrapped.
// Configuration over APB: radix at address 0, digits_in_use at address 4;
// write only while no transfer is in flight.
// An input transfer is captured in the input register, then goes through the
// successor logic into the result register.
// Throughput is one item per clock while the receiver takes results; the input
// register and the result register each hold an item, so a new transfer is
// taken while a result waits. When the receiver stalls, the result holds and the
// input register fills; s_axis_tready drops only when both stages are full.
// Reset clears both valid flags and loads radix 2 with eight digits in use.
// Depends on ngcs_pkg, ngcs_cfg_regs and ngcs_digit_step.
`timescale 1ns / 1ps

module nary_gray_code_successor_unit import ngcs_pkg::*; #(
	parameter int MAX_DIGITS = NGCS_MAX_DIGITS,
	parameter int DIGIT_BITS = NGCS_DIGIT_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [WORD_W-1:0]  s_axis_tdata,   // [31:0] code_word
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [WORD_W-1:0]  m_axis_tdata,   // [31:0] next_word
	output logic               m_axis_tuser,   // [0] wrapped
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t              cfg;
	logic              valid_s1;
	logic [WORD_W-1:0] code_word_s1;
	logic              valid_s2;
	logic [WORD_W-1:0] next_word_s2;
	logic              wrapped_s2;
	logic [WORD_W-1:0] next_word;
	logic              wrapped;
	logic              load_s1;
	logic              load_s2;

	ngcs_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ngcs_digit_step #(
		.MAX_DIGITS (MAX_DIGITS),
		.DIGIT_BITS (DIGIT_BITS)
	) u_step (
		.cfg       (cfg),
		.code_word (code_word_s1),
		.next_word (next_word),
		.wrapped   (wrapped)
	);

	// Advance the result stage when it is empty or being drained
	assign load_s2       = valid_s1 & (~valid_s2 | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | load_s2;
	assign load_s1       = s_axis_tvalid & s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (~valid_s2 | m_axis_tready)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1)
			code_word_s1 <= s_axis_tdata;
		if (load_s2) begin
			next_word_s2 <= next_word;
			wrapped_s2   <= wrapped;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = next_word_s2;
	assign m_axis_tuser  = wrapped_s2;

endmodule
